### rtl/md5d_pkg.sv
`timescale 1ns / 1ps

package md5d_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [31:0] K_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] S_TABLE [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // source of the word written into the block buffer
  typedef enum logic [2:0] {
    SRC_IN,
    SRC_IN_PAD,
    SRC_PAD80,
    SRC_ZERO,
    SRC_LEN_LO,
    SRC_LEN_HI
  } src_t;

  typedef struct packed {
    logic push;       // write one word at the current slot
    src_t src;
    logic count;      // add the accepted beat's bytes to the total
    logic start;      // load working regs from chaining value, round 0
    logic round;      // run one round
    logic chain_add;  // fold working regs into chaining value
    logic emit;       // move digest to output, restore initial state
  } dp_cmd_t;

  typedef struct packed {
    logic pos_14;
    logic pos_15;
    logic round_last;
    logic out_busy;
  } dp_status_t;

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] r4;
    logic [3:0] g;
    r4 = r[3:0];
    case (r[5:4])
      2'd0:    g = r4;
      2'd1:    g = 4'(5 * r4 + 1);
      2'd2:    g = 4'(3 * r4 + 5);
      default: g = 4'(7 * r4);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_fn(input logic [1:0] grp, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (grp)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (d & b) | (~d & c);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

endpackage

### rtl/md5_digest_unit.sv
`timescale 1ns / 1ps

// MD5 over a stream of 32-bit little-endian words (first byte in bits 7:0);
// the final beat carries 0 to 4 message bytes. A word is taken only in the
// idle state, not while a block is padded, compressed or emitted. The word
// that completes a 64-byte block also starts the compression: 64 rounds,
// one per cycle through a single round unit, then an add into the chaining
// value. After the final beat the padding and length words are written one
// per cycle, apart from the compression of each block they close (one or
// two), and then the digest is moved to the output register. The digest
// leaves as two 64-bit beats, bytes 0-7 with last_res low, then bytes 8-15
// with last_res high; the next message may be fed while they wait, and a
// new digest waits until both have gone.

module md5_digest_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_part,
  output logic        last_res
);
  import md5d_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  md5d_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .valid_bytes (valid_bytes),
    .last        (last),
    .status      (status),
    .cmd         (cmd)
  );

  md5d_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_word   (data_word),
    .valid_bytes (valid_bytes),
    .last        (last),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_part (digest_part),
    .last_res    (last_res)
  );

  // compression only starts on the write that fills the last slot
  a_start_on_full: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> (cmd.push && status.pos_15))
    else $error("compression started before block was full");

  // no buffer write while rounds are reading the block
  a_no_push_in_rounds: assert property (@(posedge clk) disable iff (rst)
    cmd.round |-> (!cmd.push && !in_ready))
    else $error("block buffer written during rounds");

  // a new digest never overwrites one still being sent
  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_valid)
    else $error("digest emitted over pending output");

  a_emit_first_half: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (out_valid && !last_res))
    else $error("digest output did not start with first half");

  a_second_half_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_res) |=> !out_valid)
    else $error("output still valid after second half beat");

endmodule

### rtl/md5d_ctrl.sv
`timescale 1ns / 1ps

module md5d_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             valid_bytes,
  input  logic                   last,
  input  md5d_pkg::dp_status_t   status,
  output md5d_pkg::dp_cmd_t      cmd
);
  import md5d_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_ADD,
    S_EMIT
  } state_t;

  state_t state, state_next;
  logic   fin, fin_next;          // message is being finished
  logic   pend80, pend80_next;    // pad byte still owed as a word of its own
  logic   lo_sent, lo_sent_next;  // low length word written
  logic   done, done_next;        // high length word written

  always_comb begin
    cmd          = '0;
    cmd.src      = SRC_ZERO;
    in_ready     = 1'b0;
    state_next   = state;
    fin_next     = fin;
    pend80_next  = pend80;
    lo_sent_next = lo_sent;
    done_next    = done;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.push  = 1'b1;
          cmd.count = 1'b1;
          cmd.src   = (last && !valid_bytes[2]) ? SRC_IN_PAD : SRC_IN;
          fin_next    = last;
          pend80_next = last && valid_bytes[2];
          if (status.pos_15) begin
            cmd.start  = 1'b1;
            state_next = S_COMP;
          end else if (last) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.push = 1'b1;
        if (pend80) begin
          cmd.src     = SRC_PAD80;
          pend80_next = 1'b0;
        end else if (status.pos_14) begin
          cmd.src      = SRC_LEN_LO;
          lo_sent_next = 1'b1;
        end else if (status.pos_15 && lo_sent) begin
          cmd.src   = SRC_LEN_HI;
          done_next = 1'b1;
        end else begin
          cmd.src = SRC_ZERO;
        end
        if (status.pos_15) begin
          cmd.start  = 1'b1;
          state_next = S_COMP;
        end
      end
      S_COMP: begin
        cmd.round = 1'b1;
        if (status.round_last) state_next = S_ADD;
      end
      S_ADD: begin
        cmd.chain_add = 1'b1;
        if (!fin)      state_next = S_IDLE;
        else if (done) state_next = S_EMIT;
        else           state_next = S_PAD;
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit     = 1'b1;
          fin_next     = 1'b0;
          lo_sent_next = 1'b0;
          done_next    = 1'b0;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fin     <= 1'b0;
      pend80  <= 1'b0;
      lo_sent <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      fin     <= fin_next;
      pend80  <= pend80_next;
      lo_sent <= lo_sent_next;
      done    <= done_next;
    end
  end

endmodule

### rtl/md5d_dp.sv
`timescale 1ns / 1ps

module md5d_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            data_word,
  input  logic [2:0]             valid_bytes,
  input  logic                   last,
  input  md5d_pkg::dp_cmd_t      cmd,
  output md5d_pkg::dp_status_t   status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [63:0]            digest_part,
  output logic                   last_res
);
  import md5d_pkg::*;

  logic [31:0]  mblk [16];
  logic [3:0]   pos;
  logic [60:0]  byte_total;
  logic [5:0]   round;
  logic [31:0]  cv_a, cv_b, cv_c, cv_d;
  logic [31:0]  wa, wb, wc, wd;
  logic [127:0] dig;
  logic         out_half;

  logic [2:0]   nbytes;
  logic [63:0]  bit_len;
  logic [31:0]  pad_word;
  logic [31:0]  push_word;

  assign nbytes  = valid_bytes[2] ? 3'd4 : valid_bytes;
  assign bit_len = {byte_total, 3'b000};

  always_comb begin
    case (valid_bytes[1:0])
      2'd0:    pad_word = {24'h0, PAD_BYTE};
      2'd1:    pad_word = {16'h0, PAD_BYTE, data_word[7:0]};
      2'd2:    pad_word = {8'h0, PAD_BYTE, data_word[15:0]};
      default: pad_word = {PAD_BYTE, data_word[23:0]};
    endcase
  end

  always_comb begin
    case (cmd.src)
      SRC_IN:     push_word = data_word;
      SRC_IN_PAD: push_word = pad_word;
      SRC_PAD80:  push_word = {24'h0, PAD_BYTE};
      SRC_LEN_LO: push_word = bit_len[31:0];
      SRC_LEN_HI: push_word = bit_len[63:32];
      default:    push_word = '0;
    endcase
  end

  // one round: f + a + K + M[g], rotate, add b
  logic [31:0] f_val, sum, rot;
  logic [63:0] dbl;
  logic [4:0]  shamt;

  assign f_val = round_fn(round[5:4], wb, wc, wd);
  assign sum   = f_val + wa + K_TABLE[round] + mblk[msg_index(round)];
  assign shamt = S_TABLE[{round[5:4], round[1:0]}];
  assign dbl   = {sum, sum} << shamt;
  assign rot   = dbl[63:32];

  always_ff @(posedge clk) begin
    if (cmd.push) mblk[pos] <= push_word;
    if (cmd.start) begin
      wa <= cv_a;
      wb <= cv_b;
      wc <= cv_c;
      wd <= cv_d;
    end else if (cmd.round) begin
      wa <= wd;
      wd <= wc;
      wc <= wb;
      wb <= wb + rot;
    end
    if (cmd.emit) dig <= {cv_d, cv_c, cv_b, cv_a};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      byte_total <= '0;
      round      <= '0;
      cv_a       <= IV_A;
      cv_b       <= IV_B;
      cv_c       <= IV_C;
      cv_d       <= IV_D;
      out_valid  <= 1'b0;
      out_half   <= 1'b0;
    end else begin
      if (cmd.emit) begin
        pos        <= '0;
        byte_total <= '0;
        cv_a       <= IV_A;
        cv_b       <= IV_B;
        cv_c       <= IV_C;
        cv_d       <= IV_D;
      end else begin
        if (cmd.push) pos <= pos + 4'd1;
        if (cmd.count) begin
          byte_total <= last ? byte_total + 61'(nbytes) : byte_total + 61'd4;
        end
        if (cmd.chain_add) begin
          cv_a <= cv_a + wa;
          cv_b <= cv_b + wb;
          cv_c <= cv_c + wc;
          cv_d <= cv_d + wd;
        end
      end
      if (cmd.start)      round <= '0;
      else if (cmd.round) round <= round + 6'd1;
      if (cmd.emit) begin
        out_valid <= 1'b1;
        out_half  <= 1'b0;
      end else if (out_valid && out_ready) begin
        if (out_half) out_valid <= 1'b0;
        else          out_half  <= 1'b1;
      end
    end
  end

  assign digest_part = out_half ? dig[127:64] : dig[63:0];
  assign last_res    = out_half;

  assign status.pos_14     = (pos == 4'd14);
  assign status.pos_15     = (pos == 4'd15);
  assign status.round_last = (round == 6'd63);
  assign status.out_busy   = out_valid;

endmodule

### verif/tb_md5_digest_unit.sv
`timescale 1ns / 1ps

module tb_md5_digest_unit;

  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int DRAIN_CYCLES = 400;
  localparam int WORD_BUDGET  = 1250;
  localparam int MAX_GAP      = 19;
  localparam int SHOW_ERRORS  = 10;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [31:0] PAD_WORD = 32'h00000080;

  typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES, FILL_WALK} fill_t;

  typedef struct {
    logic [63:0] part;
    logic        hi;
  } digest_beat_t;

  class md5_scoreboard;
    logic [31:0]  sine_k [64];
    logic [4:0]   shift_amt [16];
    logic [31:0]  chain [4];
    logic [31:0]  blk [16];
    logic [3:0]   slot;
    logic [60:0]  byte_count;
    digest_beat_t digest_q [$];
    int           errors;
    int           beats_checked;
    int           messages;

    function new();
      real x;
      int  i;
      // K[i] = floor(|sin(i+1)| * 2^32)
      for (i = 0; i < 64; i++) begin
        x = $sin(real'(i + 1));
        if (x < 0.0) x = -x;
        sine_k[i] = 32'(longint'($floor(x * 4294967296.0)));
      end
      shift_amt = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
                    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
      errors = 0;
      beats_checked = 0;
      messages = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = INIT_A;
      chain[1] = INIT_B;
      chain[2] = INIT_C;
      chain[3] = INIT_D;
      slot = '0;
      byte_count = '0;
    endfunction

    function void compress();
      logic [31:0] a, b, c, d, f, t;
      logic [3:0]  g;
      logic [4:0]  s;
      int          r;
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      for (r = 0; r < 64; r++) begin
        case (r / 16)
          0: begin f = (b & c) | (~b & d); g = 4'(r); end
          1: begin f = (d & b) | (~d & c); g = 4'(5 * r + 1); end
          2: begin f = b ^ c ^ d;          g = 4'(3 * r + 5); end
          default: begin f = c ^ (b | ~d); g = 4'(7 * r); end
        endcase
        f = f + a + sine_k[r] + blk[g];
        s = shift_amt[((r >> 4) << 2) | (r & 3)];
        t = d; d = c; c = b; a = t;
        b = b + ((f << s) | (f >> (32 - s)));
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endfunction

    function void put_word(logic [31:0] w);
      blk[slot] = w;
      slot = slot + 4'd1;
      if (slot == 4'd0) compress();
    endfunction

    // one accepted input beat; a final beat closes the message
    function void note_input(logic [31:0] w, logic [2:0] nb, logic fin);
      int          n;
      logic [31:0] keep;
      logic [63:0] bitlen;
      digest_beat_t lo, hi;
      if (!fin) begin
        byte_count += 61'd4;
        put_word(w);
        return;
      end
      n = (nb > 3'd4) ? 4 : int'(nb);
      byte_count += 61'(n);
      if (n < 4) begin
        keep = (32'd1 << (8 * n)) - 32'd1;
        put_word((w & keep) | (PAD_WORD << (8 * n)));
      end else begin
        put_word(w);
        put_word(PAD_WORD);
      end
      while (slot != 4'd14) put_word(32'd0);
      bitlen = {byte_count, 3'b000};
      put_word(bitlen[31:0]);
      put_word(bitlen[63:32]);
      lo.part = {chain[1], chain[0]};
      lo.hi = 1'b0;
      hi.part = {chain[3], chain[2]};
      hi.hi = 1'b1;
      digest_q.push_back(lo);
      digest_q.push_back(hi);
      messages++;
      restart();
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= SHOW_ERRORS) $display("MISMATCH: %s", msg);
    endfunction

    function void check_part(logic [63:0] part, logic hi);
      digest_beat_t want;
      if (digest_q.size() == 0) begin
        note_error($sformatf("digest beat %h last_res=%b with nothing pending", part, hi));
        return;
      end
      want = digest_q.pop_front();
      beats_checked++;
      if (part !== want.part || hi !== want.hi)
        note_error($sformatf("digest_part exp %h got %h, last_res exp %b got %b",
                             want.part, part, want.hi, hi));
    endfunction

    function int pending();
      return digest_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] data_word = '0;
  logic [2:0]  valid_bytes = '0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] digest_part;
  logic        last_res;

  md5_digest_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_word   (data_word),
    .valid_bytes (valid_bytes),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_part (digest_part),
    .last_res    (last_res)
  );

  md5_scoreboard sb = new();
  int  cycles = 0;
  int  words_sent = 0;
  int  longest_msg = 0;
  bit  in_burst = 1'b0;
  bit  out_burst = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d digest beats pending", cycles, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_word(input logic [31:0] w, input logic [2:0] nb, input logic fin);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_word   <= w;
    valid_bytes <= nb;
    last        <= fin;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w, nb, fin);
    words_sent++;
  endtask

  function automatic logic [31:0] fill_word(fill_t mode, int idx);
    case (mode)
      FILL_ZEROS: return 32'h0;
      FILL_ONES:  return 32'hffffffff;
      FILL_WALK:  return 32'h1 << (idx % 32);
      default:    return $urandom();
    endcase
  endfunction

  // non-final beats get a random valid_bytes, which the block must ignore
  task automatic send_message(input int nwords, input logic [2:0] final_nb, input fill_t mode);
    int i;
    for (i = 0; i < nwords - 1; i++)
      send_word(fill_word(mode, i), 3'($urandom_range(0, 7)), 1'b0);
    send_word(fill_word(mode, nwords - 1), final_nb, 1'b1);
    if (nwords > longest_msg) longest_msg = nwords;
  endtask

  // digest side: random stalls per beat, with stretches of none
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) out_burst = !out_burst;
      gap = out_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_part(digest_part, last_res);
    end
  end

  initial begin
    int   nwords;
    int   pick;
    int   nb;
    fill_t mode;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty message: pad lands in bits 7:0, set data bits must be masked
    send_message(1, 3'd0, FILL_ONES);
    // every final byte count, oversized ones included
    for (nb = 1; nb <= 7; nb++)
      send_message(1, 3'(nb), (nb % 2) ? FILL_ONES : FILL_ZEROS);
    // 60 bytes then pad: length no longer fits, so two blocks close
    send_message(15, 3'd4, FILL_RANDOM);

    while (words_sent < WORD_BUDGET) begin
      in_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 5)
        nwords = $urandom_range(1, 20);
      else if (pick < 8)
        nwords = 16 * $urandom_range(0, 3) + $urandom_range(12, 17);
      else
        nwords = $urandom_range(21, 90);
      if (nwords < 1) nwords = 1;
      pick = $urandom_range(0, 9);
      mode = (pick < 7) ? FILL_RANDOM : (pick == 7) ? FILL_ZEROS :
             (pick == 8) ? FILL_ONES : FILL_WALK;
      send_message(nwords, 3'($urandom_range(0, 7)), mode);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("hashed %0d messages in %0d words (longest %0d words)",
             sb.messages, words_sent, longest_msg);
    $display("checked %0d digest beats, %0d mismatches, %0d cycles",
             sb.beats_checked, sb.errors, cycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
